[rtl/csstok_pkg.sv]
// csstok_pkg: shared types, constants and helper functions of the CSS tokenizer.
// No dependencies.
`default_nettype none
package csstok_pkg;

  typedef enum logic [11:0] {
    M_IDLE    = 12'b000000000001,
    M_SLASH   = 12'b000000000010,
    M_COMMENT = 12'b000000000100,
    M_CSTAR   = 12'b000000001000,
    M_AT      = 12'b000000010000,
    M_HASH    = 12'b000000100000,
    M_BANG    = 12'b000001000000,
    M_DOT     = 12'b000010000000,
    M_NUM     = 12'b000100000000,
    M_UNIT    = 12'b001000000000,
    M_IDENT   = 12'b010000000000,
    M_STRING  = 12'b100000000000
  } mode_e;

  localparam logic [4:0] T_NONE      = 5'd0;   // text and unit records
  localparam logic [4:0] T_EOF       = 5'd0;
  localparam logic [4:0] T_COLON     = 5'd1;
  localparam logic [4:0] T_SEMICOLON = 5'd2;
  localparam logic [4:0] T_LBRACE    = 5'd3;
  localparam logic [4:0] T_RBRACE    = 5'd4;
  localparam logic [4:0] T_LPAREN    = 5'd5;
  localparam logic [4:0] T_RPAREN    = 5'd6;
  localparam logic [4:0] T_LBRACKET  = 5'd7;
  localparam logic [4:0] T_RBRACKET  = 5'd8;
  localparam logic [4:0] T_COMMA     = 5'd9;
  localparam logic [4:0] T_AT        = 5'd10;
  localparam logic [4:0] T_IMPORTANT = 5'd11;
  localparam logic [4:0] T_DELIM     = 5'd12;
  localparam logic [4:0] T_HASH      = 5'd13;
  localparam logic [4:0] T_PERCENT   = 5'd14;
  localparam logic [4:0] T_DIMENSION = 5'd15;
  localparam logic [4:0] T_NUMBER    = 5'd16;
  localparam logic [4:0] T_FUNCTION  = 5'd17;
  localparam logic [4:0] T_IDENT     = 5'd18;
  localparam logic [4:0] T_STRING    = 5'd19;

  localparam logic [1:0] K_TEXT = 2'd0;
  localparam logic [1:0] K_UNIT = 2'd1;
  localparam logic [1:0] K_END  = 2'd2;

  localparam int unsigned KW_LEN = 9;

  typedef struct packed {
    logic [1:0]  record_kind;
    logic [4:0]  token_type;
    logic [7:0]  char_out;
    logic [15:0] int_part;
    logic [13:0] frac_value;
    logic [2:0]  frac_digits;
    logic        last_result;
  } rec_t;

  // datapath commands from the controller
  typedef struct packed {
    logic       num_clear;
    logic       num_frac;     // start number in fraction
    logic       set_frac;     // '.' inside number
    logic       add_digit;
    logic [3:0] digit;
    logic       match_wr;
    logic [3:0] match_idx;
    logic [7:0] match_byte;
  } dp_cmd_t;

  typedef struct packed {
    logic        in_fraction;
    logic [15:0] int_accum;
    logic [13:0] frac_accum;
    logic [2:0]  frac_count;
  } dp_sts_t;

  function automatic logic [7:0] keyword_char(input logic [3:0] i);
    case (i)
      4'd0: keyword_char = "i";
      4'd1: keyword_char = "m";
      4'd2: keyword_char = "p";
      4'd3: keyword_char = "o";
      4'd4: keyword_char = "r";
      4'd5: keyword_char = "t";
      4'd6: keyword_char = "a";
      4'd7: keyword_char = "n";
      4'd8: keyword_char = "t";
      default: keyword_char = 8'd0;
    endcase
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    is_ws = c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D || c == 8'h0C;
  endfunction
  function automatic logic is_digit(input logic [7:0] c);
    is_digit = c inside {["0":"9"]};
  endfunction
  function automatic logic is_istart(input logic [7:0] c);
    is_istart = c inside {["a":"z"], ["A":"Z"], "_", "-"};
  endfunction
  function automatic logic is_ichar(input logic [7:0] c);
    is_ichar = is_istart(c) || is_digit(c);
  endfunction

endpackage
`default_nettype wire

[rtl/csstok_if.sv]
// csstok_in_if / csstok_out_if: valid-ready channels.
// Depends on csstok_pkg.
`default_nettype none
interface csstok_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] text_byte;
  modport source (output valid, req_type, text_byte, input ready);
  modport sink   (input valid, req_type, text_byte, output ready);
endinterface

interface csstok_out_if;
  logic              valid;
  logic              ready;
  csstok_pkg::rec_t  rec;
  modport source (output valid, rec, input ready);
  modport sink   (input valid, rec, output ready);
endinterface
`default_nettype wire

[rtl/csstok_datapath.sv]
// csstok_datapath: number accumulators and the !important match buffer.
// Depends on csstok_pkg.
`default_nettype none
module csstok_datapath (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire csstok_pkg::dp_cmd_t cmd_i,
  input  wire logic [3:0]          rd_idx_i,
  output logic [7:0]               rd_byte_o,
  output csstok_pkg::dp_sts_t      sts_o
);
  logic [15:0] int_q, int_d;
  logic [13:0] frac_q, frac_d;
  logic [2:0]  fcnt_q, fcnt_d;
  logic        infr_q, infr_d;
  logic [7:0]  mbuf_q [csstok_pkg::KW_LEN];
  logic [7:0]  rd_q;
  logic [19:0] int_x;
  logic        fr;

  always_comb begin
    int_d  = int_q;
    frac_d = frac_q;
    fcnt_d = fcnt_q;
    infr_d = infr_q;
    if (cmd_i.num_clear) begin
      int_d = '0; frac_d = '0; fcnt_d = '0; infr_d = cmd_i.num_frac;
    end
    if (cmd_i.set_frac) infr_d = 1'b1;
    fr = cmd_i.num_clear ? cmd_i.num_frac : infr_q;
    int_x = {4'd0, int_d} * 20'd10 + {16'd0, cmd_i.digit};
    if (cmd_i.add_digit) begin
      if (fr) begin
        if (fcnt_d < 3'd4) begin
          frac_d = 14'(frac_d * 14'd10 + {10'd0, cmd_i.digit});
          fcnt_d = fcnt_d + 3'd1;
        end
      end else begin
        int_d = (int_x > 20'd65535) ? 16'hFFFF : int_x[15:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      int_q <= '0; frac_q <= '0; fcnt_q <= '0; infr_q <= 1'b0;
    end else begin
      int_q <= int_d; frac_q <= frac_d; fcnt_q <= fcnt_d; infr_q <= infr_d;
    end
  end

  // registered read: rd_idx_i is the address wanted in the next cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.match_wr) mbuf_q[cmd_i.match_idx] <= cmd_i.match_byte;
    rd_q <= mbuf_q[rd_idx_i];
  end

  assign rd_byte_o = rd_q;
  assign sts_o = '{in_fraction: infr_q, int_accum: int_q,
                   frac_accum: frac_q, frac_count: fcnt_q};
endmodule
`default_nettype wire

[rtl/csstok_ctrl.sv]
// csstok_ctrl: scan mode state machine; at most one record per unstalled cycle.
// Depends on csstok_pkg and csstok_if.
`default_nettype none
module csstok_ctrl #(
  parameter int unsigned TEXT_MAX = 64,
  parameter int unsigned UNIT_MAX = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  csstok_in_if.sink                in_if,
  csstok_out_if.source             out_if,
  output csstok_pkg::dp_cmd_t      cmd_o,
  output logic [3:0]               rd_idx_o,
  input  wire logic [7:0]          rd_byte_i,
  input  wire csstok_pkg::dp_sts_t sts_i
);
  localparam int unsigned TW = $clog2(TEXT_MAX);
  localparam int unsigned UW = $clog2(UNIT_MAX);

  // A held item is worked on step by step; each cycle yields at most
  // one record. hold_q means an item waits; its next step runs when the
  // output register is free.
  csstok_pkg::mode_e mode_q, mode_d;
  logic [TW-1:0] tcnt_q, tcnt_d;
  logic [UW-1:0] ucnt_q, ucnt_d;
  logic [3:0]    mcnt_q, mcnt_d;
  logic          dq_q, dq_d;
  logic          hold_q, hold_d;
  logic          heot_q, heot_d;
  logic [7:0]    hb_q, hb_d;
  // replay: sending matched letters, then optional ident end (at eof)
  logic          rep_q, rep_d;
  logic [3:0]    rpos_q, rpos_d;
  logic          post_q, post_d;     // eof pass: pending token closed, eof next
  logic          ovalid_q, ovalid_d;
  csstok_pkg::rec_t orec_q, orec_d;
  // pending slot: holds a record until it is known whether it is the last
  logic          pend_q, pend_d;
  csstok_pkg::rec_t prec_q, prec_d;

  logic          go, emit, done, slot_free;
  csstok_pkg::rec_t rec;
  logic [7:0]    b, lc;

  assign in_if.ready   = !hold_q;
  assign out_if.valid  = ovalid_q;
  assign out_if.rec    = orec_q;
  assign slot_free = !ovalid_q || out_if.ready;
  assign go = hold_q && slot_free;
  assign b  = hb_q;
  assign rd_idx_o = rpos_d;

  function automatic csstok_pkg::rec_t mk(input logic [1:0] k, input logic [4:0] t,
                                          input logic [7:0] c);
    csstok_pkg::rec_t r;
    r = '0;
    r.record_kind = k; r.token_type = t; r.char_out = c;
    return r;
  endfunction

  always_comb begin
    csstok_pkg::rec_t nr;
    mode_d = mode_q; tcnt_d = tcnt_q; ucnt_d = ucnt_q; mcnt_d = mcnt_q;
    dq_d = dq_q; hold_d = hold_q; heot_d = heot_q; hb_d = hb_q;
    rep_d = rep_q; rpos_d = rpos_q; post_d = post_q;
    cmd_o = '0;
    emit = 1'b0; done = 1'b0; rec = '0;
    nr = '0;
    nr.record_kind = csstok_pkg::K_END;
    nr.int_part = sts_i.int_accum; nr.frac_value = sts_i.frac_accum;
    nr.frac_digits = sts_i.frac_count;
    lc = (b inside {["A":"Z"]}) ? b + 8'd32 : b;
    if (in_if.valid && in_if.ready) begin
      hold_d = 1'b1; heot_d = in_if.req_type; hb_d = in_if.text_byte;
    end
    if (go) begin
      if (rep_q) begin
        // replay one matched letter as ident text
        if (rpos_q < mcnt_q) begin
          if ({{(8-TW){1'b0}}, tcnt_q} < 8'(TEXT_MAX - 1)) begin
            emit = 1'b1; rec = mk(csstok_pkg::K_TEXT, csstok_pkg::T_NONE, rd_byte_i);
            tcnt_d = tcnt_q + 1'b1;
          end
          rpos_d = rpos_q + 4'd1;
        end else begin
          rep_d = 1'b0; mcnt_d = '0;
          if (heot_q) begin
            emit = 1'b1; rec = mk(csstok_pkg::K_END, csstok_pkg::T_IDENT, 8'd0);
            mode_d = csstok_pkg::M_IDLE; post_d = 1'b1;
          end
        end
      end else if (heot_q) begin
        if (post_q) begin
          emit = 1'b1; rec = mk(csstok_pkg::K_END, csstok_pkg::T_EOF, 8'd0);
          done = 1'b1;
          mode_d = csstok_pkg::M_IDLE; tcnt_d = '0; ucnt_d = '0; mcnt_d = '0;
          dq_d = 1'b0; post_d = 1'b0; cmd_o.num_clear = 1'b1;
        end else begin
          post_d = 1'b1; emit = 1'b1; mode_d = csstok_pkg::M_IDLE;
          case (mode_q)
            csstok_pkg::M_SLASH: rec = mk(csstok_pkg::K_END, csstok_pkg::T_DELIM, "/");
            csstok_pkg::M_AT:    rec = mk(csstok_pkg::K_END, csstok_pkg::T_AT, 8'd0);
            csstok_pkg::M_HASH:  rec = mk(csstok_pkg::K_END, csstok_pkg::T_HASH, 8'd0);
            csstok_pkg::M_IDENT: rec = mk(csstok_pkg::K_END, csstok_pkg::T_IDENT, 8'd0);
            csstok_pkg::M_STRING: rec = mk(csstok_pkg::K_END, csstok_pkg::T_STRING, 8'd0);
            csstok_pkg::M_DOT:   rec = mk(csstok_pkg::K_END, csstok_pkg::T_DELIM, ".");
            csstok_pkg::M_NUM: begin
              rec = nr; rec.token_type = csstok_pkg::T_NUMBER;
            end
            csstok_pkg::M_UNIT: begin
              rec = nr; rec.token_type = csstok_pkg::T_DIMENSION;
            end
            csstok_pkg::M_BANG: begin
              rec = mk(csstok_pkg::K_END, csstok_pkg::T_DELIM, "!");
              if (mcnt_q != 4'd0) begin
                post_d = 1'b0; rep_d = 1'b1; rpos_d = '0; tcnt_d = '0;
                mode_d = csstok_pkg::M_IDENT;
              end
            end
            default: begin
              emit = 1'b0;
            end
          endcase
        end
      end else begin
        done = 1'b1;
        case (mode_q)
          csstok_pkg::M_SLASH: begin
            if (b == "*") mode_d = csstok_pkg::M_COMMENT;
            else begin
              emit = 1'b1; rec = mk(csstok_pkg::K_END, csstok_pkg::T_DELIM, "/");
              mode_d = csstok_pkg::M_IDLE; done = 1'b0;
            end
          end
          csstok_pkg::M_COMMENT: if (b == "*") mode_d = csstok_pkg::M_CSTAR;
          csstok_pkg::M_CSTAR: begin
            if (b == "/") mode_d = csstok_pkg::M_IDLE;
            else if (b != "*") mode_d = csstok_pkg::M_COMMENT;
          end
          csstok_pkg::M_AT, csstok_pkg::M_HASH, csstok_pkg::M_IDENT: begin
            if (csstok_pkg::is_ichar(b)) begin
              if ({{(8-TW){1'b0}}, tcnt_q} < 8'(TEXT_MAX - 1)) begin
                emit = 1'b1; rec = mk(csstok_pkg::K_TEXT, csstok_pkg::T_NONE, b);
                tcnt_d = tcnt_q + 1'b1;
              end
            end else if (mode_q == csstok_pkg::M_IDENT && b == "(") begin
              emit = 1'b1; rec = mk(csstok_pkg::K_END, csstok_pkg::T_FUNCTION, 8'd0);
              mode_d = csstok_pkg::M_IDLE;
            end else begin
              emit = 1'b1; done = 1'b0; mode_d = csstok_pkg::M_IDLE;
              rec = mk(csstok_pkg::K_END,
                       mode_q == csstok_pkg::M_AT ? csstok_pkg::T_AT :
                       (mode_q == csstok_pkg::M_HASH ? csstok_pkg::T_HASH :
                        csstok_pkg::T_IDENT), 8'd0);
            end
          end
          csstok_pkg::M_BANG: begin
            if (mcnt_q == 4'd0 && csstok_pkg::is_ws(b)) begin
            end else if (mcnt_q < 4'(csstok_pkg::KW_LEN) &&
                         lc == csstok_pkg::keyword_char(mcnt_q)) begin
              cmd_o.match_wr = 1'b1; cmd_o.match_idx = mcnt_q; cmd_o.match_byte = b;
              if (mcnt_q == 4'(csstok_pkg::KW_LEN - 1)) begin
                emit = 1'b1;
                rec = mk(csstok_pkg::K_END, csstok_pkg::T_IMPORTANT, 8'd0);
                mode_d = csstok_pkg::M_IDLE; mcnt_d = '0;
              end else mcnt_d = mcnt_q + 4'd1;
            end else begin
              emit = 1'b1; done = 1'b0;
              rec = mk(csstok_pkg::K_END, csstok_pkg::T_DELIM, "!");
              if (mcnt_q != 4'd0) begin
                rep_d = 1'b1; rpos_d = '0; tcnt_d = '0; mode_d = csstok_pkg::M_IDENT;
              end else mode_d = csstok_pkg::M_IDLE;
            end
          end
          csstok_pkg::M_DOT: begin
            if (csstok_pkg::is_digit(b)) begin
              mode_d = csstok_pkg::M_NUM; cmd_o.num_clear = 1'b1; cmd_o.num_frac = 1'b1;
              cmd_o.add_digit = 1'b1; cmd_o.digit = b[3:0];
            end else begin
              emit = 1'b1; done = 1'b0;
              rec = mk(csstok_pkg::K_END, csstok_pkg::T_DELIM, ".");
              mode_d = csstok_pkg::M_IDLE;
            end
          end
          csstok_pkg::M_NUM: begin
            if (csstok_pkg::is_digit(b)) begin
              cmd_o.add_digit = 1'b1; cmd_o.digit = b[3:0];
            end else if (b == "." && !sts_i.in_fraction) cmd_o.set_frac = 1'b1;
            else if (b == "%") begin
              emit = 1'b1; rec = nr; rec.token_type = csstok_pkg::T_PERCENT;
              mode_d = csstok_pkg::M_IDLE;
            end else if (csstok_pkg::is_istart(b)) begin
              mode_d = csstok_pkg::M_UNIT; ucnt_d = '0;
              if (UNIT_MAX > 1) begin
                emit = 1'b1; rec = mk(csstok_pkg::K_UNIT, csstok_pkg::T_NONE, b);
                ucnt_d = UW'(1);
              end
            end else begin
              emit = 1'b1; done = 1'b0; rec = nr; rec.token_type = csstok_pkg::T_NUMBER;
              mode_d = csstok_pkg::M_IDLE;
            end
          end
          csstok_pkg::M_UNIT: begin
            if (csstok_pkg::is_ichar(b)) begin
              if ({{(8-UW){1'b0}}, ucnt_q} < 8'(UNIT_MAX - 1)) begin
                emit = 1'b1; rec = mk(csstok_pkg::K_UNIT, csstok_pkg::T_NONE, b);
                ucnt_d = ucnt_q + 1'b1;
              end
            end else begin
              emit = 1'b1; done = 1'b0; rec = nr; rec.token_type = csstok_pkg::T_DIMENSION;
              mode_d = csstok_pkg::M_IDLE;
            end
          end
          csstok_pkg::M_STRING: begin
            if (b == (dq_q ? 8'h22 : 8'h27)) begin
              emit = 1'b1; rec = mk(csstok_pkg::K_END, csstok_pkg::T_STRING, 8'd0);
              mode_d = csstok_pkg::M_IDLE;
            end else if ({{(8-TW){1'b0}}, tcnt_q} < 8'(TEXT_MAX - 1)) begin
              emit = 1'b1; rec = mk(csstok_pkg::K_TEXT, csstok_pkg::T_NONE, b);
              tcnt_d = tcnt_q + 1'b1;
            end
          end
          default: begin
            mode_d = csstok_pkg::M_IDLE;
            if (csstok_pkg::is_ws(b)) begin
            end else if (b inside {":", ";", "{", "}", "(", ")", "[", "]", ","}) begin
              emit = 1'b1;
              case (b)
                ":": rec = mk(csstok_pkg::K_END, csstok_pkg::T_COLON, 8'd0);
                ";": rec = mk(csstok_pkg::K_END, csstok_pkg::T_SEMICOLON, 8'd0);
                "{": rec = mk(csstok_pkg::K_END, csstok_pkg::T_LBRACE, 8'd0);
                "}": rec = mk(csstok_pkg::K_END, csstok_pkg::T_RBRACE, 8'd0);
                "(": rec = mk(csstok_pkg::K_END, csstok_pkg::T_LPAREN, 8'd0);
                ")": rec = mk(csstok_pkg::K_END, csstok_pkg::T_RPAREN, 8'd0);
                "[": rec = mk(csstok_pkg::K_END, csstok_pkg::T_LBRACKET, 8'd0);
                "]": rec = mk(csstok_pkg::K_END, csstok_pkg::T_RBRACKET, 8'd0);
                default: rec = mk(csstok_pkg::K_END, csstok_pkg::T_COMMA, 8'd0);
              endcase
            end else begin
              tcnt_d = '0;
              if (b == "/") mode_d = csstok_pkg::M_SLASH;
              else if (b == "@") mode_d = csstok_pkg::M_AT;
              else if (b == "#") mode_d = csstok_pkg::M_HASH;
              else if (b == "!") begin
                mode_d = csstok_pkg::M_BANG; mcnt_d = '0;
              end else if (b == ".") mode_d = csstok_pkg::M_DOT;
              else if (csstok_pkg::is_digit(b)) begin
                mode_d = csstok_pkg::M_NUM; cmd_o.num_clear = 1'b1;
                cmd_o.add_digit = 1'b1; cmd_o.digit = b[3:0];
              end else if (csstok_pkg::is_istart(b)) begin
                mode_d = csstok_pkg::M_IDENT;
                emit = 1'b1; rec = mk(csstok_pkg::K_TEXT, csstok_pkg::T_NONE, b);
                tcnt_d = TW'(1);
              end else if (b == 8'h22 || b == 8'h27) begin
                mode_d = csstok_pkg::M_STRING; dq_d = (b == 8'h22);
              end else begin
                emit = 1'b1; rec = mk(csstok_pkg::K_END, csstok_pkg::T_DELIM, b);
              end
            end
          end
        endcase
      end
      if (done) hold_d = 1'b0;
    end
  end

  // Output side. A new record pushes the pending one out; when the item
  // finishes, the record in hand is flagged last. Two records at once: the
  // pending one leaves now and the final one waits, already flagged.
  always_comb begin
    ovalid_d = ovalid_q && !out_if.ready;
    orec_d = orec_q; pend_d = pend_q; prec_d = prec_q;
    if (go) begin
      if (emit) begin
        if (pend_q) begin
          ovalid_d = 1'b1; orec_d = prec_q;
        end
        if (done && !pend_q) begin
          ovalid_d = 1'b1; orec_d = rec; orec_d.last_result = 1'b1; pend_d = 1'b0;
        end else begin
          pend_d = 1'b1; prec_d = rec; prec_d.last_result = done;
        end
      end else if (done && pend_q) begin
        ovalid_d = 1'b1; orec_d = prec_q; orec_d.last_result = 1'b1; pend_d = 1'b0;
      end
    end else if (pend_q && prec_q.last_result && slot_free) begin
      ovalid_d = 1'b1; orec_d = prec_q; pend_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= csstok_pkg::M_IDLE; tcnt_q <= '0; ucnt_q <= '0; mcnt_q <= '0;
      dq_q <= 1'b0; hold_q <= 1'b0; heot_q <= 1'b0; rep_q <= 1'b0; rpos_q <= '0;
      post_q <= 1'b0; ovalid_q <= 1'b0; pend_q <= 1'b0; hb_q <= '0;
      orec_q <= '0; prec_q <= '0;
    end else begin
      mode_q <= mode_d; tcnt_q <= tcnt_d; ucnt_q <= ucnt_d; mcnt_q <= mcnt_d;
      dq_q <= dq_d; hold_q <= hold_d; heot_q <= heot_d; rep_q <= rep_d;
      rpos_q <= rpos_d; post_q <= post_d; hb_q <= hb_d;
      ovalid_q <= ovalid_d; orec_q <= orec_d; pend_q <= pend_d; prec_q <= prec_d;
    end
  end
endmodule
`default_nettype wire

[rtl/css_tokenizer_unit.sv]
// css_tokenizer_unit: top level of the streaming CSS tokenizer.
// Depends on csstok_pkg, csstok_if, csstok_ctrl and csstok_datapath.
//
//  channel | dir | fields                           | accepted when
//  in_if   | in  | req_type, text_byte              | valid && ready
//  out_if  | out | rec (record_kind .. last_result) | valid && ready
//
// A word is accepted, then worked off one step per cycle: one for its byte,
// one for each byte looked at again after it closes a token, one per replayed
// letter and one to leave a !important replay; an end word takes a close step
// and an eof step. Ready is low while a word is held.
// A record waits in a pending slot until the next record or the end of its
// word, so that the last one can be flagged; output stalls freeze the steps.
// Reset clears all control state; the match buffer is never cleared.
`default_nettype none
module css_tokenizer_unit #(
  parameter int unsigned TEXT_MAX = 64,
  parameter int unsigned UNIT_MAX = 16
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  csstok_in_if.sink    in_if,
  csstok_out_if.source out_if
);
  csstok_pkg::dp_cmd_t cmd;
  csstok_pkg::dp_sts_t sts;
  logic [3:0] rd_idx;
  logic [7:0] rd_byte;

  csstok_ctrl #(.TEXT_MAX(TEXT_MAX), .UNIT_MAX(UNIT_MAX)) u_ctrl (
    .clk_i, .rst_ni, .in_if, .out_if,
    .cmd_o(cmd), .rd_idx_o(rd_idx), .rd_byte_i(rd_byte), .sts_i(sts)
  );

  csstok_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .rd_idx_i(rd_idx), .rd_byte_o(rd_byte), .sts_o(sts)
  );
endmodule
`default_nettype wire
